>>> hdl/cau_pkg.sv
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam int DIV_STEPS  = 32;
    localparam int ROOT_STEPS = 32;
    localparam int CORDIC_STEPS = 28;

    localparam logic signed [15:0] PHASE_LIMIT = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [35:0] PI_Q30      = 36'sh0C90FDAA0;

    localparam logic signed [35:0] ATAN_TAB [CORDIC_STEPS] = '{
        36'sh03243F6A8, 36'sh01DAC6705, 36'sh00FADBAFC, 36'sh007F56EA6,
        36'sh003FEAB76, 36'sh001FFD55B, 36'sh000FFFAAA, 36'sh0007FFF55,
        36'sh0003FFFEA, 36'sh0001FFFFD, 36'sh0000FFFFF, 36'sh00007FFFF,
        36'sh00003FFFF, 36'sh00001FFFF, 36'sh00000FFFF, 36'sh000007FFF,
        36'sh000003FFF, 36'sh000001FFF, 36'sh000000FFF, 36'sh0000007FF,
        36'sh0000003FF, 36'sh0000001FF, 36'sh0000000FF, 36'sh00000007F,
        36'sh00000003F, 36'sh00000001F, 36'sh00000000F, 36'sh000000008
    };

    // one quotient lane of the restoring divider
    typedef struct packed {
        logic        neg;
        logic        sat;
        logic [63:0] rem;
        logic [31:0] zlo;
        logic [31:0] q;
    } dlane_t;

    typedef struct packed {
        op_t         op;
        logic        dz;
        logic [63:0] den;
        dlane_t      re;
        dlane_t      im;
        logic [31:0] pre_re;
        logic [31:0] pre_im;
        logic        pre_ovf;
    } dstg_t;

    // root and cordic stages share one register slice
    typedef struct packed {
        logic [31:0]        re;
        logic [31:0]        im;
        logic               dz;
        logic               ovf;
        logic               ax;
        logic signed [15:0] ax_ph;
        logic [63:0]        rem;
        logic [63:0]        res;
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [35:0] z;
    } kstg_t;

    // {ovf, value}: wrap check on a 33-bit sum
    function automatic logic [32:0] clamp33(input logic [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31])
            r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // {ovf, value}: sign-magnitude to saturated two's complement
    function automatic logic [32:0] apply_sign(input logic neg, input logic [47:0] r);
        logic [47:0] lim;
        logic [47:0] m;
        logic        ovf;
        lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
        ovf = (r > lim);
        m   = ovf ? lim : r;
        return {ovf, neg ? 32'(-m) : m[31:0]};
    endfunction

    function automatic dlane_t div_step(input dlane_t l, input logic [63:0] den);
        dlane_t      n;
        logic [64:0] rt;
        logic        ge;
        n  = l;
        rt = {l.rem, l.zlo[31]};
        ge = (rt >= {1'b0, den});
        n.rem = ge ? 64'(rt - {1'b0, den}) : rt[63:0];
        n.zlo = {l.zlo[30:0], 1'b0};
        n.q   = {l.q[30:0], ge};
        return n;
    endfunction

    function automatic dstg_t div_stage(input dstg_t s);
        dstg_t n;
        n    = s;
        n.re = div_step(s.re, s.den);
        n.im = div_step(s.im, s.den);
        return n;
    endfunction

    function automatic logic [32:0] div_final(input dlane_t l, input logic [63:0] den);
        logic [32:0] q1;
        if (l.sat)
            q1 = 33'h0_FFFF_FFFF;
        else
            q1 = {1'b0, l.q} + 33'(({l.rem, 1'b0} >= {1'b0, den}) ? 1 : 0);
        return apply_sign(l.neg, 48'(q1));
    endfunction

    function automatic kstg_t root_step(input kstg_t s, input int k);
        kstg_t       n;
        logic [63:0] bitv;
        logic [63:0] t;
        n    = s;
        bitv = 64'd1 << (62 - 2 * k);
        t    = s.res + bitv;
        if (s.rem >= t) begin
            n.rem = s.rem - t;
            n.res = (s.res >> 1) + bitv;
        end else begin
            n.res = s.res >> 1;
        end
        return n;
    endfunction

    function automatic kstg_t cordic_step(input kstg_t s, input int k);
        kstg_t n;
        n = s;
        if (s.y > 36'sd0) begin
            n.x = s.x + (s.y >>> k);
            n.y = s.y - (s.x >>> k);
            n.z = s.z + ATAN_TAB[k];
        end else begin
            n.x = s.x - (s.y >>> k);
            n.y = s.y + (s.x >>> k);
            n.z = s.z - ATAN_TAB[k];
        end
        return n;
    endfunction

endpackage

>>> hdl/complex_arithmetic_unit_top.sv
// Channel  Dir  tdata (low bit up)                        tuser
// s_axis   in   a_real, a_imag, b_real, b_imag (128 bits)  opcode
// m_axis   out  res_real, res_imag, magnitude, phase       div_by_zero, overflow
//
// Pipelined: one request per cycle while the output is not stalled.
// The 32-step divider and the 32-step root/cordic chain set the pipeline depth.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
module complex_arithmetic_unit_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
    input  logic [1:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // res_real, res_imag, magnitude, phase
    output logic [1:0]   m_axis_tuser   // div_by_zero, overflow
);
    import cau_pkg::*;

    localparam int D0   = 2;
    localparam int FIN  = D0 + DIV_STEPS + 1;
    localparam int K0   = FIN + 3;
    localparam int NSTG = K0 + ROOT_STEPS + 2;

    logic            en;
    logic [NSTG-1:0] vld_reg;

    logic signed [31:0] a, b, c, d;

    // S1: products, add/sub sums
    op_t                s1_op_reg;
    logic signed [63:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [32:0] s1_re_reg, s1_im_reg;

    // S2: sums
    op_t                s2_op_reg;
    logic signed [64:0] num_re_reg, num_im_reg;
    logic [63:0]        den_reg;
    logic [32:0]        as_re_reg, as_im_reg;

    // S3 comb
    logic        neg_re, neg_im;
    logic [63:0] mag_re, mag_im;
    logic [64:0] rnd_re, rnd_im;
    logic [32:0] mr_re, mr_im;
    dstg_t       d_next;

    dstg_t d_reg [DIV_STEPS+1];

    // FIN
    logic [32:0] dq_re, dq_im;
    logic [31:0] fin_re_reg, fin_im_reg;
    logic        fin_dz_reg, fin_ovf_reg;

    // B0
    logic [31:0]        b0_re_reg, b0_im_reg;
    logic               b0_dz_reg, b0_ovf_reg, b0_ax_reg;
    logic signed [15:0] b0_ph_reg;
    logic [63:0]        sq_re_reg, sq_im_reg;
    logic signed [32:0] b0_x_reg, b0_y_reg;
    logic signed [35:0] b0_z_reg;

    // B1
    logic [31:0]        b1_re_reg, b1_im_reg;
    logic               b1_dz_reg, b1_ovf_reg, b1_ax_reg;
    logic signed [15:0] b1_ph_reg;
    logic [63:0]        sum_reg;
    logic signed [32:0] b1_x_reg, b1_y_reg;
    logic signed [35:0] b1_z_reg;
    logic [4:0]         sh_reg;
    logic [32:0]        ay, mx;
    logic [5:0]         msb;
    logic [4:0]         sh_next;

    kstg_t k_reg [ROOT_STEPS+1];
    kstg_t k_next;

    // F
    logic [63:0]        root;
    logic signed [35:0] zr_full;
    logic signed [18:0] zr;
    logic signed [15:0] ph;
    logic [111:0]       out_data_reg;
    logic [1:0]         out_user_reg;

    assign en            = ~vld_reg[NSTG-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign a = s_axis_tdata[31:0];
    assign b = s_axis_tdata[63:32];
    assign c = s_axis_tdata[95:64];
    assign d = s_axis_tdata[127:96];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
    end

    // ---------------- S1 ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= op_t'(s_axis_tuser);
            ac_reg    <= a * c;
            bd_reg    <= b * d;
            ad_reg    <= a * d;
            bc_reg    <= b * c;
            cc_reg    <= c * c;
            dd_reg    <= d * d;
            if (op_t'(s_axis_tuser) == OP_SUB)
            begin
                s1_re_reg <= 33'(a) - 33'(c);
                s1_im_reg <= 33'(b) - 33'(d);
            end
            else
            begin
                s1_re_reg <= 33'(a) + 33'(c);
                s1_im_reg <= 33'(b) + 33'(d);
            end
        end
    end

    // ---------------- S2 ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg <= s1_op_reg;
            den_reg   <= 64'(cc_reg) + 64'(dd_reg);
            as_re_reg <= clamp33(s1_re_reg);
            as_im_reg <= clamp33(s1_im_reg);
            if (s1_op_reg == OP_DIV)
            begin
                num_re_reg <= 65'(ac_reg) + 65'(bd_reg);
                num_im_reg <= 65'(bc_reg) - 65'(ad_reg);
            end
            else
            begin
                num_re_reg <= 65'(ac_reg) - 65'(bd_reg);
                num_im_reg <= 65'(ad_reg) + 65'(bc_reg);
            end
        end
    end

    // ---------------- S3: sign/magnitude, mult rounding, divider setup ----------------
    always_comb
    begin
        neg_re = num_re_reg[64];
        neg_im = num_im_reg[64];
        mag_re = neg_re ? 64'(-num_re_reg) : num_re_reg[63:0];
        mag_im = neg_im ? 64'(-num_im_reg) : num_im_reg[63:0];
        rnd_re = (65'(mag_re) + 65'h8000) >> 16;
        rnd_im = (65'(mag_im) + 65'h8000) >> 16;
        mr_re  = apply_sign(neg_re, rnd_re[47:0]);
        mr_im  = apply_sign(neg_im, rnd_im[47:0]);

        d_next.op  = s2_op_reg;
        d_next.dz  = (den_reg == 64'd0);
        d_next.den = den_reg;

        d_next.re.neg = neg_re;
        d_next.re.sat = ({16'd0, mag_re[63:16]} >= den_reg);
        d_next.re.rem = {16'd0, mag_re[63:16]};
        d_next.re.zlo = {mag_re[15:0], 16'd0};
        d_next.re.q   = '0;
        d_next.im.neg = neg_im;
        d_next.im.sat = ({16'd0, mag_im[63:16]} >= den_reg);
        d_next.im.rem = {16'd0, mag_im[63:16]};
        d_next.im.zlo = {mag_im[15:0], 16'd0};
        d_next.im.q   = '0;

        if (s2_op_reg == OP_MUL)
        begin
            d_next.pre_re  = mr_re[31:0];
            d_next.pre_im  = mr_im[31:0];
            d_next.pre_ovf = mr_re[32] | mr_im[32];
        end
        else
        begin
            d_next.pre_re  = as_re_reg[31:0];
            d_next.pre_im  = as_im_reg[31:0];
            d_next.pre_ovf = as_re_reg[32] | as_im_reg[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg[0] <= d_next;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
                d_reg[k+1] <= div_stage(d_reg[k]);
        end
    end

    // ---------------- FIN: quotient rounding and result select ----------------
    assign dq_re = div_final(d_reg[DIV_STEPS].re, d_reg[DIV_STEPS].den);
    assign dq_im = div_final(d_reg[DIV_STEPS].im, d_reg[DIV_STEPS].den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_reg[DIV_STEPS].op != OP_DIV)
            begin
                fin_re_reg  <= d_reg[DIV_STEPS].pre_re;
                fin_im_reg  <= d_reg[DIV_STEPS].pre_im;
                fin_ovf_reg <= d_reg[DIV_STEPS].pre_ovf;
                fin_dz_reg  <= 1'b0;
            end
            else if (d_reg[DIV_STEPS].dz)
            begin
                fin_re_reg  <= '0;
                fin_im_reg  <= '0;
                fin_ovf_reg <= 1'b0;
                fin_dz_reg  <= 1'b1;
            end
            else
            begin
                fin_re_reg  <= dq_re[31:0];
                fin_im_reg  <= dq_im[31:0];
                fin_ovf_reg <= dq_re[32] | dq_im[32];
                fin_dz_reg  <= 1'b0;
            end
        end
    end

    // ---------------- B0: squares, phase prep ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_re_reg  <= fin_re_reg;
            b0_im_reg  <= fin_im_reg;
            b0_dz_reg  <= fin_dz_reg;
            b0_ovf_reg <= fin_ovf_reg;
            sq_re_reg  <= 64'($signed(fin_re_reg) * $signed(fin_re_reg));
            sq_im_reg  <= 64'($signed(fin_im_reg) * $signed(fin_im_reg));

            // results on an axis get an exact phase
            if (fin_im_reg == 32'd0)
            begin
                b0_ax_reg <= 1'b1;
                b0_ph_reg <= fin_re_reg[31] ? PHASE_LIMIT : 16'sd0;
            end
            else if (fin_re_reg == 32'd0)
            begin
                b0_ax_reg <= 1'b1;
                b0_ph_reg <= fin_im_reg[31] ? -HALF_PI_Q13 : HALF_PI_Q13;
            end
            else
            begin
                b0_ax_reg <= 1'b0;
                b0_ph_reg <= 16'sd0;
            end

            // left half plane: rotate by pi first
            if (fin_re_reg[31])
            begin
                b0_x_reg <= -33'($signed(fin_re_reg));
                b0_y_reg <= -33'($signed(fin_im_reg));
                b0_z_reg <= fin_im_reg[31] ? -PI_Q30 : PI_Q30;
            end
            else
            begin
                b0_x_reg <= 33'($signed(fin_re_reg));
                b0_y_reg <= 33'($signed(fin_im_reg));
                b0_z_reg <= 36'sd0;
            end
        end
    end

    // ---------------- B1: sum of squares, normalize count ----------------
    always_comb
    begin
        ay = b0_y_reg[32] ? 33'(-b0_y_reg) : 33'(b0_y_reg);
        mx = (33'(b0_x_reg) > ay) ? 33'(b0_x_reg) : ay;
        msb = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (mx[i])
                msb = 6'(i);
        end
        sh_next = (msb >= 6'd30) ? 5'd0 : 5'(6'd30 - msb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_re_reg  <= b0_re_reg;
            b1_im_reg  <= b0_im_reg;
            b1_dz_reg  <= b0_dz_reg;
            b1_ovf_reg <= b0_ovf_reg;
            b1_ax_reg  <= b0_ax_reg;
            b1_ph_reg  <= b0_ph_reg;
            sum_reg    <= sq_re_reg + sq_im_reg;
            b1_x_reg   <= b0_x_reg;
            b1_y_reg   <= b0_y_reg;
            b1_z_reg   <= b0_z_reg;
            sh_reg     <= sh_next;
        end
    end

    // ---------------- B2: apply shift, seed root ----------------
    always_comb
    begin
        k_next.re    = b1_re_reg;
        k_next.im    = b1_im_reg;
        k_next.dz    = b1_dz_reg;
        k_next.ovf   = b1_ovf_reg;
        k_next.ax    = b1_ax_reg;
        k_next.ax_ph = b1_ph_reg;
        k_next.rem   = sum_reg;
        k_next.res   = '0;
        k_next.x     = 36'(b1_x_reg) <<< sh_reg;
        k_next.y     = 36'(b1_y_reg) <<< sh_reg;
        k_next.z     = b1_z_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            k_reg[0] <= k_next;
    end

    // one root bit per stage, plus one cordic rotation in each of the first CORDIC_STEPS stages
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        if (k < CORDIC_STEPS)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (en)
                    k_reg[k+1] <= cordic_step(root_step(k_reg[k], k), k);
            end
        end
        else
        begin : g_plain
            always_ff @(posedge clk)
            begin
                if (en)
                    k_reg[k+1] <= root_step(k_reg[k], k);
            end
        end
    end

    // ---------------- F: round and pack ----------------
    always_comb
    begin
        root    = (k_reg[ROOT_STEPS].rem > k_reg[ROOT_STEPS].res) ?
                  k_reg[ROOT_STEPS].res + 64'd1 : k_reg[ROOT_STEPS].res;
        zr_full = (k_reg[ROOT_STEPS].z + 36'sh000010000) >>> 17;
        zr      = zr_full[18:0];
        if (k_reg[ROOT_STEPS].ax)
            ph = k_reg[ROOT_STEPS].ax_ph;
        else if (zr > 19'(PHASE_LIMIT))
            ph = PHASE_LIMIT;
        else if (zr < -19'(PHASE_LIMIT))
            ph = -PHASE_LIMIT;
        else
            ph = zr[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {ph, root[31:0], k_reg[ROOT_STEPS].im, k_reg[ROOT_STEPS].re};
            out_user_reg <= {k_reg[ROOT_STEPS].ovf, k_reg[ROOT_STEPS].dz};
        end
    end

endmodule

>>> hdl/cau_check.sv
module cau_check (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // with nothing waiting at the output the pipe must take requests
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 112'd0 && !m_axis_tuser[1])
        else $error("zero divisor result not cleared");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:64] <= 32'd3037000500
            && $signed(m_axis_tdata[111:96]) <= 16'sd25736
            && $signed(m_axis_tdata[111:96]) >= -16'sd25736)
        else $error("magnitude or phase out of range");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[63:0] == 64'd0 |-> m_axis_tdata[111:64] == 48'd0)
        else $error("zero result with nonzero magnitude or phase");

endmodule

bind complex_arithmetic_unit_top cau_check u_cau_check (.*);

>>> tb/testbench.sv
module testbench;
    import cau_pkg::*;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [31:0]        mag;
        logic signed [15:0] ph;
        logic               dz;
        logic               ovf;
    } cres_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    cres_t pending_results[$];
    int    mismatches;
    int    hold_cycles;
    bit    stim_done;

    complex_arithmetic_unit_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint shr_arith(longint x, int k);
        return x >>> k;
    endfunction

    // saturate a sign/magnitude value to 32 bits
    function automatic longint sat_sm(bit neg, longint unsigned r, ref bit ovf);
        longint unsigned lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (r > lim)
        begin
            r = lim;
            ovf = 1;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint sat_int(longint v, ref bit ovf);
        if (v > 64'sh7FFF_FFFF)
        begin
            ovf = 1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            ovf = 1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // p + q as sign and magnitude, |p|,|q| <= 2^62
    function automatic longint unsigned add_sm(longint p, longint q, ref bit neg);
        longint unsigned s;
        s = longint'(p) + longint'(q);
        if (s == 64'h8000_0000_0000_0000)
            neg = (p < 0);
        else
            neg = (s > 64'h8000_0000_0000_0000);
        return neg ? (~s) + 1 : s;
    endfunction

    function automatic longint quot_q16(bit neg, longint unsigned m, longint unsigned d,
                                        ref bit ovf);
        longint unsigned q, r;
        q = m / d;
        r = m % d;
        if (q >= 64'h10000)
            return sat_sm(neg, 64'hFFFF_FFFF, ovf);
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        if (r >= d - r)
            q++;
        return sat_sm(neg, q, ovf);
    endfunction

    function automatic longint unsigned isqrt_round(longint unsigned s);
        longint unsigned res, b, rem;
        res = 0;
        b = 64'd1 << 62;
        rem = s;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (rem > res)
            res++;
        return res;
    endfunction

    function automatic logic signed [15:0] angle_q13(longint x, longint y);
        longint z, nx, ny, r;
        z = 0;
        if (y == 0)
            return (x < 0) ? PHASE_LIMIT : 16'sd0;
        if (x == 0)
            return (y > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
        if (x < 0)
        begin
            z = (y > 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        while (x < (64'sd1 << 30) && y < (64'sd1 << 30) && y > -(64'sd1 << 30))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + shr_arith(y, i);
                ny = y - shr_arith(x, i);
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x - shr_arith(y, i);
                ny = y + shr_arith(x, i);
                z = z - longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        r = shr_arith(z + 64'h10000, 17);
        if (r > PHASE_LIMIT)
            r = PHASE_LIMIT;
        if (r < -PHASE_LIMIT)
            r = -PHASE_LIMIT;
        return 16'(r);
    endfunction

    function automatic cres_t complex_op(op_t op, logic signed [31:0] ar, logic signed [31:0] ai,
                                         logic signed [31:0] br, logic signed [31:0] bi);
        cres_t           o;
        longint          a, b, c, d, re, im;
        longint unsigned m, den;
        bit              ovf, neg, dz;
        a = ar;
        b = ai;
        c = br;
        d = bi;
        re = 0;
        im = 0;
        ovf = 0;
        dz = 0;
        case (op)
            OP_ADD:
            begin
                re = sat_int(a + c, ovf);
                im = sat_int(b + d, ovf);
            end
            OP_SUB:
            begin
                re = sat_int(a - c, ovf);
                im = sat_int(b - d, ovf);
            end
            OP_MUL:
            begin
                m = add_sm(a * c, -(b * d), neg);
                re = sat_sm(neg, (m + 64'h8000) >> 16, ovf);
                m = add_sm(a * d, b * c, neg);
                im = sat_sm(neg, (m + 64'h8000) >> 16, ovf);
            end
            default:
            begin
                den = longint'(c * c) + longint'(d * d);
                if (den == 0)
                    dz = 1;
                else
                begin
                    m = add_sm(a * c, b * d, neg);
                    re = quot_q16(neg, m, den, ovf);
                    m = add_sm(b * c, -(a * d), neg);
                    im = quot_q16(neg, m, den, ovf);
                end
            end
        endcase
        o.re = 32'(re);
        o.im = 32'(im);
        o.dz = dz;
        o.ovf = ovf;
        o.mag = dz ? 32'd0 : 32'(isqrt_round(longint'(re * re) + longint'(im * im)));
        o.ph = dz ? 16'sd0 : angle_q13(re, im);
        return o;
    endfunction

    // tvalid stays up after a request unless a gap follows
    task automatic send_request(op_t op, logic [31:0] ar, logic [31:0] ai,
                                logic [31:0] br, logic [31:0] bi, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bi, br, ai, ar};
        s_axis_tuser  <= op;
        pending_results.push_back(complex_op(op, ar, ai, br, bi));
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
            4: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_edges();
        logic [31:0] vals[6];
        vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h1};
        for (int k = 0; k < 4; k++)
        begin
            send_request(op_t'(k), vals[0], vals[1], vals[1], vals[0], 0);
            send_request(op_t'(k), vals[3], vals[4], vals[5], vals[2], 1);
        end
        // zero divisor, axis phases, negative real, max magnitude
        send_request(OP_DIV, vals[3], vals[3], 32'h0, 32'h0, 0);
        send_request(OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 0);
        send_request(OP_ADD, vals[4], 32'h0, 32'h0, 32'h0, 0);
        send_request(OP_ADD, 32'h0, vals[3], 32'h0, 32'h0, 0);
        send_request(OP_ADD, 32'h0, vals[4], 32'h0, 32'h0, 0);
        send_request(OP_SUB, vals[4], vals[3], 32'h0, 32'h0, 0);
        send_request(OP_SUB, vals[4], vals[4], 32'h0, 32'h0, 0);
        send_request(OP_MUL, vals[0], vals[0], vals[1], vals[0], 0);
        send_request(OP_DIV, vals[1], vals[0], vals[5], 32'h0, 0);
        send_request(OP_DIV, vals[3], 32'h0, 32'h0, vals[5], 2);
        send_request(OP_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0, 0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_request(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand(), rand_gap());
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        for (int n = 0; n < 120; n++)
            send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, 0);
        wait_drained();
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        cres_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata !== {exp_r.ph, exp_r.mag, exp_r.im, exp_r.re}
                    || m_axis_tuser !== {exp_r.ovf, exp_r.dz})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp re %h im %h mag %h ph %h dz %b ovf %b, got %h/%b",
                                 exp_r.re, exp_r.im, exp_r.mag, exp_r.ph, exp_r.dz, exp_r.ovf,
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        mismatches = 0;
        hold_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        test_random(650);
        test_backpressure();
        wait_drained();
        test_random(750);
        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
